[sv/assert_macros.svh]
// Assertion macros used by the base64 encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, checked in every cycle including reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/b64lw_pkg.sv]
// Types, constants and the alphabet function of the base64 line-wrapped encoder.
package b64lw_pkg;

  localparam logic [7:0] NEWLINE_CHAR   = 8'd10;
  localparam logic [7:0] PAD_CHAR       = 8'd61;
  localparam logic [7:0] LINE_LEN_RESET = 8'd76;
  localparam logic [2:0] GRP_CHARS      = 3'd4;
  localparam logic [2:0] GRP_CHARS_NL   = 3'd5;

  // One finished group: up to five characters, first one in the low byte.
  typedef struct packed {
    logic        vld;
    logic        last;
    logic [2:0]  cnt;
    logic [39:0] chars;
  } b64lw_grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd71 + {2'b00, s};
    end else if (s < 6'd62) begin
      c = {2'b00, s} - 8'd4;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

[sv/b64lw_group_builder.sv]
// Byte collector: gathers groups of up to three bytes, maps them to characters, tracks the line column.
module b64lw_group_builder
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] line_len,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       grp_take,
  output b64lw_grp_t grp
);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  col_r, col_nxt;
  b64lw_grp_t  grp_r, grp_nxt;

  logic        fire;
  logic [23:0] word;
  logic [8:0]  col_sum;
  logic        wrap;
  logic [7:0]  c2, c3;

  assign in_ready = !grp_r.vld || grp_take;
  assign fire     = in_valid && in_ready;
  assign grp      = grp_r;

  always_comb begin
    case (fill_r)
      2'd0:    word = {in_byte, 16'h0000};
      2'd1:    word = {held_r[7:0], in_byte, 8'h00};
      default: word = {held_r, in_byte};
    endcase
    col_sum = {1'b0, col_r} + 9'd4;
    wrap    = in_last || (col_sum >= {1'b0, line_len}) || col_sum[8];
    c2      = (fill_r != 2'd0) ? b64_char(word[11:6]) : PAD_CHAR;
    c3      = (fill_r == 2'd2) ? b64_char(word[5:0]) : PAD_CHAR;
  end

  always_comb begin
    held_nxt = held_r;
    fill_nxt = fill_r;
    col_nxt  = col_r;
    grp_nxt  = grp_r;
    if (grp_take) begin
      grp_nxt.vld = 1'b0;
    end
    if (fire) begin
      if (!in_last && fill_r != 2'd2) begin
        held_nxt = {held_r[7:0], in_byte};
        fill_nxt = fill_r + 2'd1;
      end else begin
        held_nxt      = 16'h0000;
        fill_nxt      = 2'd0;
        col_nxt       = wrap ? 8'd0 : col_sum[7:0];
        grp_nxt.vld   = 1'b1;
        grp_nxt.last  = in_last;
        grp_nxt.cnt   = wrap ? GRP_CHARS_NL : GRP_CHARS;
        grp_nxt.chars = {NEWLINE_CHAR, c3, c2, b64_char(word[17:12]),
                         b64_char(word[23:18])};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 16'h0000;
      fill_r  <= 2'd0;
      col_r   <= 8'd0;
      grp_r   <= '0;
    end else begin
      held_r  <= held_nxt;
      fill_r  <= fill_nxt;
      col_r   <= col_nxt;
      grp_r   <= grp_nxt;
    end
  end

endmodule

[sv/b64lw_char_serializer.sv]
// Output shift register: sends the characters of one group, one per transaction.
`include "assert_macros.svh"
module b64lw_char_serializer
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64lw_grp_t grp,
  output logic       grp_take,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic [39:0] sh_r, sh_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        last_r, last_nxt;
  logic        fire;

  assign out_tvalid = (rem_r != 3'd0);
  assign out_tdata  = sh_r[7:0];
  assign out_tlast  = last_r && (rem_r == 3'd1);
  assign fire       = out_tvalid && out_tready;
  assign grp_take   = grp.vld && ((rem_r == 3'd0) || (rem_r == 3'd1 && out_tready));

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (grp_take) begin
      sh_nxt   = grp.chars;
      rem_nxt  = grp.cnt;
      last_nxt = grp.last;
    end else if (fire) begin
      sh_nxt  = {8'h00, sh_r[39:8]};
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 3'd0;
      last_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  `ASSERT_CLK(a_rem_range, rem_r <= GRP_CHARS_NL, "character count above five")
  `ASSERT_CLK(a_load_cnt, grp_take |=> rem_r == $past(grp.cnt), "group load lost its count")
  `ASSERT_CLK(a_last_nl, out_tlast |-> out_tdata == NEWLINE_CHAR, "stream end not a newline")

endmodule

[sv/base64_line_wrapped_encoder_unit.sv]
// Top level of the base64 line-wrapped encoder.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  in_tdata = data_byte, in_tlast = last_byte
//   out_     out  out_tvalid/out_tready out_tdata = out_char, out_tlast = out_last
//   cfg_     in   cfg_wr_en            cfg_wr_data = line_length
//
// A byte is taken whenever the group register is free or its group is being
// handed to the serializer, whether it only joins a group or completes one.
// Each group leaves as four or five characters, one per cycle from the output
// shift register while out_tready is high.
// in_tready drops only while a finished group waits behind the one being sent.
// Synchronous active-low reset clears the control state (not the output shift register) and sets line length to 76.
module base64_line_wrapped_encoder_unit
  import b64lw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_char
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] line_len_r;
  b64lw_grp_t grp;
  logic       grp_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= LINE_LEN_RESET;
    end else if (cfg_wr_en) begin
      line_len_r <= cfg_wr_data;
    end
  end

  b64lw_group_builder u_builder (
    .clk      (clk),
    .rst_n    (rst_n),
    .line_len (line_len_r),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .grp_take (grp_take),
    .grp      (grp)
  );

  b64lw_char_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp        (grp),
    .grp_take   (grp_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the base64 line-wrapped encoder: directed and random streams.
module tb_top;
  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } enc_char_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // encoder shadow state
  logic [7:0]  line_len = LINE_LEN_RESET;
  logic [15:0] held = 16'd0;
  logic [1:0]  fill = 2'd0;
  logic [7:0]  column = 8'd0;

  enc_char_t expected_chars[$];
  int        mismatch_count = 0;
  int        bytes_sent = 0;
  bit        sender_steady = 1'b0;
  bit        receiver_steady = 1'b0;

  base64_line_wrapped_encoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL base64_line_wrapped_encoder_unit");
    $finish;
  end

  function automatic logic [7:0] sextet_ascii(input logic [23:0] word, input int shift);
    logic [5:0] s;
    s = word[shift +: 6];
    return ALPHABET[8*(63 - s) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic lst);
    enc_char_t c;
    c.ch = ch;
    c.lst = lst;
    expected_chars.push_back(c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [23:0] word;
    logic [8:0]  col;
    int          count;
    if (!lst && fill < 2'd2) begin
      held = {held[7:0], b};
      fill = fill + 2'd1;
    end else begin
      count = int'(fill) + 1;
      if (count == 1) word = {b, 16'd0};
      else if (count == 2) word = {held[7:0], b, 8'd0};
      else word = {held, b};
      push_char(sextet_ascii(word, 18), 1'b0);
      push_char(sextet_ascii(word, 12), 1'b0);
      push_char(count >= 2 ? sextet_ascii(word, 6) : PAD_CHAR, 1'b0);
      push_char(count >= 3 ? sextet_ascii(word, 0) : PAD_CHAR, 1'b0);
      held = 16'd0;
      fill = 2'd0;
      col = {1'b0, column} + 9'd4;
      if (lst) begin
        push_char(NEWLINE_CHAR, 1'b1);
        column = 8'd0;
      end else if (col >= {1'b0, line_len} || col > 9'd255) begin
        push_char(NEWLINE_CHAR, 1'b0);
        column = 8'd0;
      end else begin
        column = col[7:0];
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    encode_byte(b, lst);
    bytes_sent++;
  endtask

  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_line_length(input logic [7:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    line_len = v;
  endtask

  // one, two and three byte groups, all-zero and all-one bytes
  task automatic test_padding();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // shortest line, zero line length, length not a multiple of four
  task automatic test_line_wrap();
    set_line_length(8'd4);
    send_stream(5);
    set_line_length(8'd0);
    send_stream(3);
    set_line_length(8'd6);
    send_stream(6);
  endtask

  task automatic test_random_streams();
    int start;
    int pick;
    start = bytes_sent;
    while (bytes_sent - start < 45) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: set_line_length(8'd4);
        1: set_line_length(8'd252);
        2: set_line_length(8'(4 * $urandom_range(1, 63)));
        3: set_line_length(8'($urandom_range(0, 255)));
        default: begin
        end
      endcase
      repeat ($urandom_range(1, 2)) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) send_stream($urandom_range(13, 20));
        else send_stream($urandom_range(1, 12));
      end
    end
    sender_steady = 1'b0;
  endtask

  // several wraps at a length off a multiple of four, then the widest length and the reset length
  task automatic test_long_stream();
    set_line_length(8'd30);
    send_stream(48);
    set_line_length(8'd255);
    send_stream(6);
    set_line_length(LINE_LEN_RESET);
    send_stream(7);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_padding();
    test_line_wrap();
    test_random_streams();
    test_long_stream();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS base64_line_wrapped_encoder_unit");
    end else begin
      $display("FAIL base64_line_wrapped_encoder_unit");
    end
    $finish;
  end

  initial begin
    int        stall;
    enc_char_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction char=%0d last=%0b",
                                  out_tdata, out_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.ch)
          report_mismatch($sformatf("char %0d, expected %0d", out_tdata, want.ch));
        if (out_tlast !== want.lst)
          report_mismatch($sformatf("last %0b, expected %0b", out_tlast, want.lst));
      end
      if ($urandom_range(0, 15) == 0) receiver_steady = !receiver_steady;
    end
  end

endmodule
